### rtl/rabs_pkg.sv
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared types and constants of the running average background subtractor:
// register map, command codes, port payloads and size defaults.
// ----------------------------------------------------------------------------
package rabs_pkg;

  localparam int MAX_WIDTH_DEF     = 512;
  localparam int MAX_HEIGHT_DEF    = 256;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 10;
  localparam int FH_W       = 9;
  localparam int THR_W      = 9;
  localparam int RATE_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int ALPHA_SHIFT = 16;
  localparam logic [RATE_W-1:0] ALPHA_ONE = RATE_W'(1) << ALPHA_SHIFT;

  localparam logic [FW_W-1:0]   FRAME_WIDTH_RST   = FW_W'(320);
  localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST  = FH_W'(240);
  localparam logic [THR_W-1:0]  DIST_THRESH_RST   = THR_W'(25);
  localparam logic [RATE_W-1:0] LEARNING_RATE_RST = RATE_W'(655);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DIST_THRESHOLD = 2'd2,
    REG_LEARNING_RATE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } in_payload_t;

  typedef struct packed {
    logic foreground;
    logic priming;
    logic last_of_frame;
  } out_payload_t;

  typedef struct packed {
    logic priming;
    logic last;
  } pix_tag_t;

endpackage

### rtl/rabs_bg_mem.sv
// ----------------------------------------------------------------------------
// rabs_bg_mem
// Background store: one entry per pixel position, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module rabs_bg_mem #(
  parameter int DEPTH  = rabs_pkg::MAX_WIDTH_DEF * rabs_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_W = 17,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/rabs_seq.sv
// ----------------------------------------------------------------------------
// rabs_seq
// Raster position sequencer: column, row and linear address of the next
// pixel, and the flags that mark the first-frame load and the frame's last pixel.
// ----------------------------------------------------------------------------
module rabs_seq #(
  parameter int COL_W  = 9,
  parameter int ROW_W  = 8,
  parameter int ADDR_W = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic               step,
  input  logic [COL_W-1:0]   w_last,
  input  logic [ROW_W-1:0]   h_last,
  output logic [ADDR_W-1:0]  addr,
  output rabs_pkg::pix_tag_t tag
);

  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [ADDR_W-1:0] addr_r;
  logic              primed_r;
  logic              col_end;
  logic              frame_end;

  assign col_end     = (col_r == w_last);
  assign frame_end   = col_end && (row_r == h_last);
  assign tag.priming = !primed_r;
  assign tag.last    = frame_end;
  assign addr        = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r    <= '0;
      row_r    <= '0;
      addr_r   <= '0;
      primed_r <= 1'b0;
    end else if (step) begin
      if (frame_end) begin
        col_r    <= '0;
        row_r    <= '0;
        addr_r   <= '0;
        primed_r <= 1'b1;
      end else if (col_end) begin
        col_r  <= '0;
        row_r  <= row_r + ROW_W'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end else begin
        col_r  <= col_r + COL_W'(1);
        addr_r <= addr_r + ADDR_W'(1);
      end
    end
  end

endmodule

### rtl/rabs_update.sv
// ----------------------------------------------------------------------------
// rabs_update
// Read-modify-write datapath: distance and blend products from the stored
// background, threshold compare, write-back and the output register.
// ----------------------------------------------------------------------------
module rabs_update #(
  parameter int ADDR_W        = 17,
  parameter int FRACTION_BITS = rabs_pkg::FRACTION_BITS_DEF,
  parameter int CH_W          = rabs_pkg::PIX_W + FRACTION_BITS,
  parameter int DATA_W        = 3 * CH_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pix_valid,
  input  logic [ADDR_W-1:0]               pix_addr,
  input  rabs_pkg::pix_tag_t              pix_tag,
  input  rabs_pkg::in_payload_t           pix_data,
  input  logic [DATA_W-1:0]               rd_data,
  input  logic [rabs_pkg::THR_W-1:0]      thr,
  input  logic [rabs_pkg::RATE_W-1:0]     alpha,
  input  logic [ADDR_W-1:0]               chk_addr,
  output logic                            conflict,
  output logic                            take_ready,
  output logic                            wr_en,
  output logic [ADDR_W-1:0]               wr_addr,
  output logic [DATA_W-1:0]               wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rabs_pkg::out_payload_t          out_payload
);

  localparam int SQ_W   = 2 * CH_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int PROD_W = CH_W + rabs_pkg::RATE_W;
  localparam int TSQ_W  = 2 * rabs_pkg::THR_W;

  logic                          s1_v_r;
  logic [ADDR_W-1:0]             s1_addr_r;
  rabs_pkg::pix_tag_t            s1_tag_r;
  logic [2:0][rabs_pkg::PIX_W-1:0] s1_pix_r;

  logic                          s2_v_r;
  logic [ADDR_W-1:0]             s2_addr_r;
  rabs_pkg::pix_tag_t            s2_tag_r;
  logic [2:0][SQ_W-1:0]          s2_sq_r;
  logic [2:0][CH_W-1:0]          s2_step_r;
  logic [2:0]                    s2_up_r;
  logic [2:0][CH_W-1:0]          s2_bg_r;
  logic [2:0][CH_W-1:0]          s2_cur_r;

  logic                          out_v_r;
  rabs_pkg::out_payload_t        out_r;
  logic [TSQ_W-1:0]              thr_sq_r;

  logic                          s1_adv;
  logic                          s2_adv;
  logic [2:0][CH_W-1:0]          s1_cur;
  logic [2:0][CH_W-1:0]          s1_bg;
  logic [2:0][CH_W-1:0]          s1_mag;
  logic [2:0]                    s1_up;
  logic [2:0][SQ_W-1:0]          s1_sq;
  logic [2:0][PROD_W-1:0]        s1_prod;
  logic [2:0][CH_W-1:0]          s1_step;

  logic [SUM_W-1:0]              dist_sq;
  logic [SUM_W-1:0]              limit;
  logic                          fg;
  logic [2:0][CH_W-1:0]          new_bg;

  assign s2_adv     = s2_v_r && (!out_v_r || out_ready);
  assign s1_adv     = s1_v_r && (!s2_v_r || s2_adv);
  assign take_ready = !s1_v_r || s1_adv;
  assign conflict   = (s1_v_r && (s1_addr_r == chk_addr)) ||
                      (s2_v_r && (s2_addr_r == chk_addr));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s1_cur[c]  = CH_W'(s1_pix_r[c]) << FRACTION_BITS;
      s1_bg[c]   = rd_data[c*CH_W +: CH_W];
      s1_up[c]   = (s1_cur[c] >= s1_bg[c]);
      s1_mag[c]  = s1_up[c] ? (s1_cur[c] - s1_bg[c]) : (s1_bg[c] - s1_cur[c]);
      s1_sq[c]   = SQ_W'(s1_mag[c]) * SQ_W'(s1_mag[c]);
      s1_prod[c] = PROD_W'(s1_mag[c]) * PROD_W'(alpha);
      s1_step[c] = s1_prod[c][rabs_pkg::ALPHA_SHIFT +: CH_W];
    end
  end

  always_comb begin
    dist_sq = SUM_W'(s2_sq_r[0]) + SUM_W'(s2_sq_r[1]) + SUM_W'(s2_sq_r[2]);
    limit   = SUM_W'(thr_sq_r) << (2 * FRACTION_BITS);
    fg      = !s2_tag_r.priming && (dist_sq > limit);
    for (int c = 0; c < 3; c++) begin
      if (s2_tag_r.priming) begin
        new_bg[c] = s2_cur_r[c];
      end else if (s2_up_r[c]) begin
        new_bg[c] = s2_bg_r[c] + s2_step_r[c];
      end else begin
        new_bg[c] = s2_bg_r[c] - s2_step_r[c];
      end
    end
  end

  assign wr_en   = s2_adv;
  assign wr_addr = s2_addr_r;
  assign wr_data = new_bg;

  always_ff @(posedge clk) begin
    thr_sq_r <= TSQ_W'(thr) * TSQ_W'(thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pix_valid) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid) begin
      s1_addr_r   <= pix_addr;
      s1_tag_r    <= pix_tag;
      s1_pix_r[0] <= pix_data.blue;
      s1_pix_r[1] <= pix_data.green;
      s1_pix_r[2] <= pix_data.red;
    end
    if (s1_adv) begin
      s2_addr_r <= s1_addr_r;
      s2_tag_r  <= s1_tag_r;
      s2_sq_r   <= s1_sq;
      s2_step_r <= s1_step;
      s2_up_r   <= s1_up;
      s2_bg_r   <= s1_bg;
      s2_cur_r  <= s1_cur;
    end
    if (s2_adv) begin
      out_r.foreground    <= fg;
      out_r.priming       <= s2_tag_r.priming;
      out_r.last_of_frame <= s2_tag_r.last;
    end
  end

  assign out_valid   = out_v_r;
  assign out_payload = out_r;

endmodule

### rtl/running_average_background_subtract.sv
// ----------------------------------------------------------------------------
// running_average_background_subtract
// Per-pixel running-average background model over a raster BGR stream, with
// a squared-distance foreground test and first-frame background load.
//
//   Channel  Ports                          Moves
//   input    in_valid/in_ready/in_payload   one pixel or clear command
//   result   out_valid/out_ready/out_payload one flag set per pixel
//   config   cfg_valid/cfg_ready/cfg_index/cfg_data  one register write
//
// One pixel transfer per cycle while in_ready is high; a result is registered
// through both pipeline stages and the output register. The memory is read on
// the transfer and written back as the pixel leaves the second stage, so a
// pixel whose entry is still in flight (frames of one or two pixels) waits for
// that write-back. A clear command gives no result. Reset is synchronous; the
// background memory needs no clearing pass as the first frame writes every
// entry before it is used. Result stalls fill both stages, then hold input.
// ----------------------------------------------------------------------------
module running_average_background_subtract #(
  parameter int MAX_WIDTH     = rabs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = rabs_pkg::MAX_HEIGHT_DEF,
  parameter int FRACTION_BITS = rabs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rabs_pkg::in_payload_t               in_payload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rabs_pkg::out_payload_t              out_payload,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rabs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CH_W   = rabs_pkg::PIX_W + FRACTION_BITS;
  localparam int DATA_W = 3 * CH_W;

  logic [rabs_pkg::FW_W-1:0]   fw_r;
  logic [rabs_pkg::FH_W-1:0]   fh_r;
  logic [rabs_pkg::THR_W-1:0]  thr_r;
  logic [rabs_pkg::RATE_W-1:0] rate_r;

  logic                  cfg_acc;
  logic                  in_acc;
  logic                  pix_acc;
  logic                  restart;
  logic                  size_wr;
  logic [31:0]           w_last_full;
  logic [31:0]           h_last_full;
  logic [COL_W-1:0]      w_last;
  logic [ROW_W-1:0]      h_last;
  logic [rabs_pkg::RATE_W-1:0] alpha;

  logic [ADDR_W-1:0]     seq_addr;
  rabs_pkg::pix_tag_t    seq_tag;
  logic                  conflict;
  logic                  take_ready;
  logic [DATA_W-1:0]     rd_data;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [DATA_W-1:0]     wr_data;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = take_ready && !(!seq_tag.priming && conflict);
  assign in_acc    = in_valid && in_ready;
  assign pix_acc   = in_acc && (in_payload.cmd == rabs_pkg::CMD_PIXEL);
  assign size_wr   = cfg_acc &&
                     ((cfg_index == rabs_pkg::REG_FRAME_WIDTH) ||
                      (cfg_index == rabs_pkg::REG_FRAME_HEIGHT));
  assign restart   = size_wr || (in_acc && (in_payload.cmd == rabs_pkg::CMD_CLEAR));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= rabs_pkg::FRAME_WIDTH_RST;
      fh_r   <= rabs_pkg::FRAME_HEIGHT_RST;
      thr_r  <= rabs_pkg::DIST_THRESH_RST;
      rate_r <= rabs_pkg::LEARNING_RATE_RST;
    end else if (cfg_acc) begin
      unique case (rabs_pkg::cfg_reg_t'(cfg_index))
        rabs_pkg::REG_FRAME_WIDTH: begin
          fw_r <= cfg_data[rabs_pkg::FW_W-1:0];
        end
        rabs_pkg::REG_FRAME_HEIGHT: begin
          fh_r <= cfg_data[rabs_pkg::FH_W-1:0];
        end
        rabs_pkg::REG_DIST_THRESHOLD: begin
          thr_r <= cfg_data[rabs_pkg::THR_W-1:0];
        end
        rabs_pkg::REG_LEARNING_RATE: begin
          rate_r <= cfg_data[rabs_pkg::RATE_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    if (fw_r == '0) begin
      w_last_full = 32'd0;
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      w_last_full = 32'(MAX_WIDTH) - 32'd1;
    end else begin
      w_last_full = 32'(fw_r) - 32'd1;
    end
    if (fh_r == '0) begin
      h_last_full = 32'd0;
    end else if (32'(fh_r) > 32'(MAX_HEIGHT)) begin
      h_last_full = 32'(MAX_HEIGHT) - 32'd1;
    end else begin
      h_last_full = 32'(fh_r) - 32'd1;
    end
  end

  assign w_last = w_last_full[COL_W-1:0];
  assign h_last = h_last_full[ROW_W-1:0];
  assign alpha  = (rate_r > rabs_pkg::ALPHA_ONE) ? rabs_pkg::ALPHA_ONE : rate_r;

  rabs_seq #(
    .COL_W  (COL_W),
    .ROW_W  (ROW_W),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .step    (pix_acc),
    .w_last  (w_last),
    .h_last  (h_last),
    .addr    (seq_addr),
    .tag     (seq_tag)
  );

  rabs_bg_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (pix_acc),
    .rd_addr (seq_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  rabs_update #(
    .ADDR_W        (ADDR_W),
    .FRACTION_BITS (FRACTION_BITS),
    .CH_W          (CH_W),
    .DATA_W        (DATA_W)
  ) u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix_acc),
    .pix_addr    (seq_addr),
    .pix_tag     (seq_tag),
    .pix_data    (in_payload),
    .rd_data     (rd_data),
    .thr         (thr_r),
    .alpha       (alpha),
    .chk_addr    (seq_addr),
    .conflict    (conflict),
    .take_ready  (take_ready),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

### tb/running_average_background_subtract_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_average_background_subtract_tb
// Self-checking bench for the background subtractor. Pixel and clear
// transfers are predicted against a behavioral background store kept in the
// bench, and every mask result is compared field by field. Directed frames
// cover the size, threshold and rate extremes; random phases follow.
// ----------------------------------------------------------------------------
module running_average_background_subtract_tb;
  import rabs_pkg::*;

  localparam int BG_W = PIX_W + FRACTION_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 750;

  typedef logic [2:0][BG_W-1:0] bg_entry_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_payload_t           in_payload = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_payload_t          out_payload;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_payload_t  pixel_feed[$];
  out_payload_t expected_masks[$];
  out_payload_t want;
  logic         pix_taken = 1'b0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           items_queued = 0;
  int           items_accepted = 0;
  int           phase_no = 0;
  int           errors = 0;
  int           masks_predicted = 0;
  int           clears_seen = 0;
  int           frames_done = 0;
  int           fg_count = 0;
  int           writes_seen = 0;

  bg_entry_t         bg_store[int unsigned];
  logic              bg_primed = 1'b0;
  int unsigned       pix_pos = 0;
  logic [FW_W-1:0]   cur_width = FRAME_WIDTH_RST;
  logic [FH_W-1:0]   cur_height = FRAME_HEIGHT_RST;
  logic [THR_W-1:0]  cur_thresh = DIST_THRESH_RST;
  logic [RATE_W-1:0] cur_rate = LEARNING_RATE_RST;

  logic [23:0] scene[0:63];
  int          gen_total = 1;
  int          gen_pos = 0;
  logic        gen_priming = 1'b1;

  running_average_background_subtract dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void predict_mask(in_payload_t px);
    int unsigned     w, h, total, pos;
    logic [BG_W-1:0] now_val[3];
    logic [BG_W-1:0] bg;
    logic [RATE_W-1:0] alpha;
    longint unsigned d, dist_sq, limit;
    bg_entry_t       entry;
    out_payload_t    r;
    if (px.cmd == CMD_CLEAR) begin
      bg_primed = 1'b0;
      pix_pos = 0;
      clears_seen++;
      return;
    end
    w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_width;
    h = (cur_height == 0) ? 1 : (cur_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : cur_height;
    total = w * h;
    pos = (pix_pos >= total) ? 0 : pix_pos;
    now_val[0] = BG_W'(px.blue) << FRACTION_BITS_DEF;
    now_val[1] = BG_W'(px.green) << FRACTION_BITS_DEF;
    now_val[2] = BG_W'(px.red) << FRACTION_BITS_DEF;
    r = '0;
    r.priming = !bg_primed;
    if (!bg_primed) begin
      for (int c = 0; c < 3; c++) entry[c] = now_val[c];
    end else begin
      entry = bg_store[pos];
      alpha = (cur_rate > ALPHA_ONE) ? ALPHA_ONE : cur_rate;
      dist_sq = 0;
      for (int c = 0; c < 3; c++) begin
        bg = entry[c];
        if (now_val[c] >= bg) begin
          d = now_val[c] - bg;
          entry[c] = bg + BG_W'((d * alpha) >> ALPHA_SHIFT);
        end else begin
          d = bg - now_val[c];
          entry[c] = bg - BG_W'((d * alpha) >> ALPHA_SHIFT);
        end
        dist_sq += d * d;
      end
      limit = (longint'(cur_thresh) * longint'(cur_thresh)) << (2 * FRACTION_BITS_DEF);
      r.foreground = dist_sq > limit;
    end
    bg_store[pos] = entry;
    r.last_of_frame = (pos + 1) == total;
    if (r.last_of_frame) begin
      pix_pos = 0;
      bg_primed = 1'b1;
      frames_done++;
    end else begin
      pix_pos = pos + 1;
    end
    if (r.foreground) fg_count++;
    masks_predicted++;
    expected_masks.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      pix_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH: begin
            cur_width = cfg_data[FW_W-1:0];
            bg_primed = 1'b0;
            pix_pos = 0;
          end
          REG_FRAME_HEIGHT: begin
            cur_height = cfg_data[FH_W-1:0];
            bg_primed = 1'b0;
            pix_pos = 0;
          end
          REG_DIST_THRESHOLD: cur_thresh = cfg_data[THR_W-1:0];
          REG_LEARNING_RATE: cur_rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
        writes_seen++;
      end
      if (in_valid && in_ready) begin
        predict_mask(in_payload);
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_masks.size() == 0) begin
          $display("%0t: unexpected result %b with no pixel pending", $time, out_payload);
          errors++;
        end else begin
          want = expected_masks.pop_front();
          if (out_payload.foreground !== want.foreground) begin
            $display("%0t: foreground expected %b, got %b", $time, want.foreground,
                     out_payload.foreground);
            errors++;
          end
          if (out_payload.priming !== want.priming) begin
            $display("%0t: priming expected %b, got %b", $time, want.priming,
                     out_payload.priming);
            errors++;
          end
          if (out_payload.last_of_frame !== want.last_of_frame) begin
            $display("%0t: last_of_frame expected %b, got %b", $time, want.last_of_frame,
                     out_payload.last_of_frame);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || pix_taken) begin
        if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_payload <= pixel_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic feed_pixel(logic cmd, logic [23:0] color);
    pixel_feed.push_back(in_payload_t'({cmd, color}));
    items_queued++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_masks.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic start_phase();
    wait_idle();
    phase_no++;
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 49; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 49; end
      default: begin send_idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  initial begin
    #2_000_000;
    $display("run timed out with %0d results outstanding", expected_masks.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    int          v, spread, pick, gw, gh, thr, n, random_pixels;
    logic [23:0] color;
    logic [16:0] rate;
    bit          sizes_known;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset size: every pixel only loads the background.
    start_phase();
    @(posedge clk);
    feed_pixel(CMD_PIXEL, 24'h000000);
    feed_pixel(CMD_PIXEL, 24'hFFFFFF);
    feed_pixel(CMD_CLEAR, 24'hA5C3E1);
    feed_pixel(CMD_PIXEL, 24'h5A3C1E);

    // Zero sizes count as one-pixel frames; zero threshold; rate saturates to one.
    start_phase();
    write_reg(REG_FRAME_WIDTH, 17'd0);
    write_reg(REG_FRAME_HEIGHT, 17'd0);
    write_reg(REG_DIST_THRESHOLD, 17'd0);
    write_reg(REG_LEARNING_RATE, 17'h1FFFF);
    @(posedge clk);
    feed_pixel(CMD_PIXEL, 24'h102030);
    feed_pixel(CMD_PIXEL, 24'h102030);
    feed_pixel(CMD_PIXEL, 24'h112030);
    feed_pixel(CMD_PIXEL, 24'h112030);

    // Two-pixel frames with opposite colors against a threshold just above the full distance.
    start_phase();
    write_reg(REG_FRAME_WIDTH, 17'd2);
    write_reg(REG_FRAME_HEIGHT, 17'd1);
    write_reg(REG_DIST_THRESHOLD, 17'd442);
    write_reg(REG_LEARNING_RATE, 17'd0);
    @(posedge clk);
    feed_pixel(CMD_PIXEL, 24'h000000);
    feed_pixel(CMD_PIXEL, 24'hFFFFFF);
    feed_pixel(CMD_PIXEL, 24'hFFFFFF);
    feed_pixel(CMD_PIXEL, 24'h000000);

    // Just below the full distance, then a clear in the middle of a frame.
    start_phase();
    write_reg(REG_DIST_THRESHOLD, 17'd441);
    @(posedge clk);
    feed_pixel(CMD_PIXEL, 24'hFFFFFF);
    feed_pixel(CMD_CLEAR, 24'h5AA55A);
    feed_pixel(CMD_PIXEL, 24'hFFFFFF);
    feed_pixel(CMD_PIXEL, 24'h000000);
    feed_pixel(CMD_PIXEL, 24'h000000);

    start_phase();
    write_reg(REG_DIST_THRESHOLD, 17'h1FFFF);
    @(posedge clk);
    feed_pixel(CMD_PIXEL, 24'hFFFFFF);
    feed_pixel(CMD_PIXEL, 24'h000000);

    // Oversized width and height clamp to the largest frame; only a few pixels load.
    start_phase();
    write_reg(REG_FRAME_WIDTH, 17'h1FFFF);
    write_reg(REG_FRAME_HEIGHT, 17'h1FFFF);
    write_reg(REG_LEARNING_RATE, 17'd65536);
    @(posedge clk);
    repeat (6) feed_pixel(CMD_PIXEL, 24'($urandom));
    feed_pixel(CMD_CLEAR, 24'($urandom));

    random_pixels = 0;
    sizes_known = 1'b0;
    while (random_pixels < RANDOM_PIXELS) begin
      start_phase();
      if (!sizes_known || $urandom_range(2) != 0) begin
        if ($urandom_range(9) == 0) begin
          gw = $urandom_range(9, 40);
          gh = 1;
        end else begin
          gw = $urandom_range(1, 8);
          gh = $urandom_range(1, 4);
        end
        write_reg(REG_FRAME_WIDTH, {7'($urandom), 10'(gw)});
        write_reg(REG_FRAME_HEIGHT, {8'($urandom), 9'(gh)});
        gen_total = gw * gh;
        gen_pos = 0;
        gen_priming = 1'b1;
        sizes_known = 1'b1;
      end
      thr = ($urandom_range(9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 45);
      write_reg(REG_DIST_THRESHOLD, {8'($urandom), 9'(thr)});
      pick = $urandom_range(9);
      if (pick == 0) rate = 17'($urandom_range(65537, 131071));
      else if (pick == 1) rate = 17'd65536;
      else if (pick == 2) rate = 17'd0;
      else rate = 17'($urandom_range(1, 40000));
      write_reg(REG_LEARNING_RATE, rate);
      @(posedge clk);
      n = gen_total * $urandom_range(2, 5);
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          feed_pixel(CMD_CLEAR, 24'($urandom));
          gen_pos = 0;
          gen_priming = 1'b1;
        end else begin
          if (gen_priming || pick < 25) begin
            color = 24'($urandom);
          end else begin
            spread = $urandom_range(0, 25);
            for (int c = 0; c < 3; c++) begin
              v = int'(scene[gen_pos][8*c +: 8]) + $urandom_range(0, 2 * spread) - spread;
              if (v < 0) v = 0;
              if (v > 255) v = 255;
              color[8*c +: 8] = v[7:0];
            end
          end
          if (gen_priming) scene[gen_pos] = color;
          feed_pixel(CMD_PIXEL, color);
          random_pixels++;
          if (gen_pos + 1 == gen_total) begin
            gen_pos = 0;
            gen_priming = 1'b0;
          end else begin
            gen_pos++;
          end
        end
      end
    end

    wait_idle();
    $display("Checked %0d mask results over %0d phases and %0d register writes.",
             masks_predicted, phase_no, writes_seen);
    $display("Saw %0d clear commands, %0d completed frames, %0d foreground pixels.",
             clears_seen, frames_done, fg_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
